// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define BQE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define BQE_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/bqe_pkg.sv =====
package bqe_pkg;

  typedef longint unsigned u64_t;

  localparam int   SINE_DEPTH_DEF = 256;
  localparam int   QUEUE_DEPTH    = 8;
  localparam int   CNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam u64_t ONE_Q30        = 64'd1073741824;
  localparam u64_t PI2_Q30        = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_RIGHT_X = 3'd0,
    REG_RIGHT_Y = 3'd1,
    REG_RIGHT_Z = 3'd2,
    REG_UP_X    = 3'd3,
    REG_UP_Y    = 3'd4,
    REG_UP_Z    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CORNER_BL = 2'd0,
    CORNER_BR = 2'd1,
    CORNER_TR = 2'd2,
    CORNER_TL = 2'd3
  } corner_e;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [17:0]      u0;
    logic [17:0]      u1;
    logic [17:0]      v0;
    logic [17:0]      v1;
    logic [31:0]      rgba;
  } base_t;

  typedef struct packed {
    base_t            base;
    logic [2:0][28:0] hr;
    logic [2:0][28:0] hu;
  } item_t;

endpackage

// ===== hdl/billboard_quad_expander_core.sv =====
// Each live particle gives four corner transfers on consecutive accepted output cycles.
// An accepted input passes the front pipeline registers, the particle queue and the current-particle register.
// Sustained throughput is set by the output, which gives one corner a cycle while out_stall_i is low.
// Input transfers are taken every cycle while the eight-entry queue, counted with live front entries, has room.
// Reset is asynchronous and active low; the axes return to right (1,0,0) and up (0,1,0).
module billboard_quad_expander_core import bqe_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               live_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  input  logic [15:0]        angle_i,
  input  logic [16:0]        tex_u_i,
  input  logic [16:0]        tex_v_i,
  input  logic [16:0]        tex_w_i,
  input  logic [16:0]        tex_h_i,
  input  logic [31:0]        rgba_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic [17:0]        coord_u_o,
  output logic [17:0]        coord_v_o,
  output logic [31:0]        vert_rgba_o,
  output logic [1:0]         corner_o,
  output logic               last_o
);

  logic                   push, pop, empty;
  item_t                  push_item, head_item;
  logic [CNT_W-1:0]       q_count;
  logic [$bits(item_t)-1:0] head_bits;

  bqe_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .live_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .width_i, .height_i, .angle_i, .tex_u_i, .tex_v_i, .tex_w_i, .tex_h_i, .rgba_i,
    .q_count_i(q_count), .push_o(push), .push_item_o(push_item)
  );

  bqe_fifo #(.WIDTH($bits(item_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_item), .pop_i(pop),
    .data_o(head_bits), .empty_o(empty), .count_o(q_count)
  );

  assign head_item = item_t'(head_bits);

  bqe_back u_back (
    .clk_i, .rst_ni, .head_i(head_item), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .vert_x_o, .vert_y_o, .vert_z_o,
    .coord_u_o, .coord_v_o, .vert_rgba_o, .corner_o, .last_o
  );

endmodule

// ===== hdl/bqe_fifo.sv =====
`include "assert_macros.svh"

module bqe_fifo import bqe_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  `BQE_NEVER(a_no_overflow, clk_i, rst_ni, push_i && !pop_i && (count_q == CW'(DEPTH)), "queue overflow")
  `BQE_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && (count_q == '0), "queue underflow")

endmodule

// ===== hdl/bqe_front.sv =====
module bqe_front import bqe_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               live_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  input  logic [15:0]        angle_i,
  input  logic [16:0]        tex_u_i,
  input  logic [16:0]        tex_v_i,
  input  logic [16:0]        tex_w_i,
  input  logic [16:0]        tex_h_i,
  input  logic [31:0]        rgba_i,
  input  logic [CNT_W-1:0]   q_count_i,
  output logic               push_o,
  output item_t              push_item_o
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = IW + 14;

  logic [14:0] sin_tab [SINE_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_tab
    localparam u64_t X  = (u64_t'(gi) * ONE_Q30) / SINE_TABLE_DEPTH;
    localparam u64_t T  = (X * PI2_Q30) >> 30;
    localparam u64_t T2 = (T * T) >> 30;
    localparam u64_t A1 = ONE_Q30 - T2 / 72;
    localparam u64_t A2 = ONE_Q30 - ((T2 * A1) >> 30) / 42;
    localparam u64_t A3 = ONE_Q30 - ((T2 * A2) >> 30) / 20;
    localparam u64_t A4 = ONE_Q30 - ((T2 * A3) >> 30) / 6;
    localparam u64_t S  = (T * A4) >> 30;
    localparam u64_t E  = (S + 64'd32768) >> 16;
    localparam u64_t EC = (E > 64'd16384) ? 64'd16384 : E;
    assign sin_tab[gi] = 15'(EC);
  end

  function automatic logic signed [15:0] sine_of(input logic [15:0] a);
    logic [PW-1:0] prod;
    logic [IW-1:0] idx;
    logic [IW-1:0] ridx;
    logic [14:0]   m;
    prod = PW'(a[13:0]) * PW'(SINE_TABLE_DEPTH);
    idx  = prod[PW-1:14];
    ridx = IW'(SINE_TABLE_DEPTH) - idx;
    m    = a[14] ? sin_tab[ridx] : sin_tab[idx];
    return a[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic signed [15:0] right_q [3];
  logic signed [15:0] up_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q[0] <= 16'sd16384;
      right_q[1] <= '0;
      right_q[2] <= '0;
      up_q[0]    <= '0;
      up_q[1]    <= 16'sd16384;
      up_q[2]    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RIGHT_X: right_q[0] <= cfg_data_i;
        REG_RIGHT_Y: right_q[1] <= cfg_data_i;
        REG_RIGHT_Z: right_q[2] <= cfg_data_i;
        REG_UP_X:    up_q[0]    <= cfg_data_i;
        REG_UP_Y:    up_q[1]    <= cfg_data_i;
        REG_UP_Z:    up_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic               v1_q, v2_q, v3_q, v4_q;
  base_t              base1_q, base2_q, base3_q, base4_q;
  logic [15:0]        w1_q, h1_q, w2_q, h2_q;
  logic signed [15:0] sin1_q, cos1_q;
  logic signed [31:0] rc2_q [3], us2_q [3], rs2_q [3], uc2_q [3];
  logic signed [49:0] mr3_q [3], mu3_q [3];
  logic [28:0]        hr4_q [3], hu4_q [3];
  logic               accept;
  logic [CNT_W+1:0]   occupancy;

  assign occupancy = (CNT_W+2)'(q_count_i) + (CNT_W+2)'(v1_q) + (CNT_W+2)'(v2_q)
                   + (CNT_W+2)'(v3_q) + (CNT_W+2)'(v4_q);
  assign in_stall_o = (occupancy >= (CNT_W+2)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept && live_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base1_q.pos[0] <= pos_x_i;
    base1_q.pos[1] <= pos_y_i;
    base1_q.pos[2] <= pos_z_i;
    base1_q.u0     <= 18'(tex_u_i);
    base1_q.v0     <= 18'(tex_v_i);
    base1_q.u1     <= 18'(tex_u_i) + 18'(tex_w_i);
    base1_q.v1     <= 18'(tex_v_i) + 18'(tex_h_i);
    base1_q.rgba   <= rgba_i;
    w1_q           <= width_i;
    h1_q           <= height_i;
    sin1_q         <= sine_of(angle_i);
    cos1_q         <= sine_of(angle_i + 16'd16384);
    base2_q        <= base1_q;
    w2_q           <= w1_q;
    h2_q           <= h1_q;
    base3_q        <= base2_q;
    base4_q        <= base3_q;
  end

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [32:0] nr, nu;
    assign nr = 33'(rc2_q[j]) - 33'(us2_q[j]);
    assign nu = 33'(rs2_q[j]) + 33'(uc2_q[j]);

    always_ff @(posedge clk_i) begin
      rc2_q[j] <= right_q[j] * cos1_q;
      us2_q[j] <= up_q[j] * sin1_q;
      rs2_q[j] <= right_q[j] * sin1_q;
      uc2_q[j] <= up_q[j] * cos1_q;
      mr3_q[j] <= 50'(nr) * 50'($signed({1'b0, w2_q}));
      mu3_q[j] <= 50'(nu) * 50'($signed({1'b0, h2_q}));
      hr4_q[j] <= 29'((mr3_q[j] + 50'sd1048576) >>> 21);
      hu4_q[j] <= 29'((mu3_q[j] + 50'sd1048576) >>> 21);
    end
  end

  assign push_o      = v4_q;
  assign push_item_o = {base4_q, hr4_q[2], hr4_q[1], hr4_q[0], hu4_q[2], hu4_q[1], hu4_q[0]};

endmodule

// ===== hdl/bqe_back.sv =====
`include "assert_macros.svh"

module bqe_back import bqe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic [17:0]        coord_u_o,
  output logic [17:0]        coord_v_o,
  output logic [31:0]        vert_rgba_o,
  output logic [1:0]         corner_o,
  output logic               last_o
);

  item_t               cur_q;
  logic                cur_valid_q;
  corner_e             k_q;
  logic                out_valid_q;
  logic signed [31:0]  vert_q [3];
  logic [17:0]         u_q, v_q;
  logic [31:0]         rgba_q;
  corner_e             corner_q;
  logic                take, step, done;
  logic                sr, su;
  logic signed [31:0]  vert_d [3];

  assign take  = !out_valid_q || !out_stall_i;
  assign step  = cur_valid_q && take;
  assign done  = step && (k_q == CORNER_TL);
  assign pop_o = (!cur_valid_q || done) && !empty_i;
  assign sr    = (k_q == CORNER_BR) || (k_q == CORNER_TR);
  assign su    = k_q[1];

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [33:0] hr, hu, sum;
    assign hr  = 34'($signed(cur_q.hr[j]));
    assign hu  = 34'($signed(cur_q.hu[j]));
    assign sum = 34'($signed(cur_q.base.pos[j])) + (sr ? hr : -hr) + (su ? hu : -hu);
    always_comb begin
      if (sum > 34'sd2147483647) begin
        vert_d[j] = 32'sh7fffffff;
      end else if (sum < -34'sd2147483648) begin
        vert_d[j] = 32'sh80000000;
      end else begin
        vert_d[j] = 32'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= CORNER_BL;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        k_q         <= CORNER_BL;
      end else if (done) begin
        cur_valid_q <= 1'b0;
      end else if (step) begin
        k_q <= corner_e'(k_q + 2'd1);
      end
      if (take) begin
        out_valid_q <= cur_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (step) begin
      vert_q   <= vert_d;
      u_q      <= sr ? cur_q.base.u1 : cur_q.base.u0;
      v_q      <= su ? cur_q.base.v1 : cur_q.base.v0;
      rgba_q   <= cur_q.base.rgba;
      corner_q <= k_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vert_x_o    = vert_q[0];
  assign vert_y_o    = vert_q[1];
  assign vert_z_o    = vert_q[2];
  assign coord_u_o   = u_q;
  assign coord_v_o   = v_q;
  assign vert_rgba_o = rgba_q;
  assign corner_o    = corner_q;
  assign last_o      = (corner_q == CORNER_TL);

  `BQE_ASSERT(a_pop_when_free, clk_i, rst_ni, pop_o |-> (!cur_valid_q || done), "pop while busy")
  `BQE_ASSERT(a_fall_on_last, clk_i, rst_ni, $fell(cur_valid_q) |-> ($past(k_q) == CORNER_TL), "quad cut short")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb import bqe_pkg::*; ();

  localparam int DEPTH = SINE_DEPTH_DEF;

  typedef struct {
    logic               live;
    logic signed [31:0] px, py, pz;
    logic [15:0]        w, h, ang;
    logic [16:0]        tu, tv, tw, th;
    logic [31:0]        rgba;
    logic               is_cfg;
    logic               drain;
    logic [2:0]         cidx;
    logic [15:0]        cval;
  } particle_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [17:0]        u, v;
    logic [31:0]        rgba;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic live = 1'b0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] width = '0, height = '0, angle = '0;
  logic [16:0] tex_u = '0, tex_v = '0, tex_w = '0, tex_h = '0;
  logic [31:0] rgba = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] vert_x, vert_y, vert_z;
  logic [17:0] coord_u, coord_v;
  logic [31:0] vert_rgba;
  logic [1:0] corner;
  logic last;

  billboard_quad_expander_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .live_i(live), .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .width_i(width), .height_i(height), .angle_i(angle),
    .tex_u_i(tex_u), .tex_v_i(tex_v), .tex_w_i(tex_w), .tex_h_i(tex_h),
    .rgba_i(rgba),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .vert_x_o(vert_x), .vert_y_o(vert_y), .vert_z_o(vert_z),
    .coord_u_o(coord_u), .coord_v_o(coord_v), .vert_rgba_o(vert_rgba),
    .corner_o(corner), .last_o(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [15:0] axis_r [3];
  logic signed [15:0] axis_u [3];
  longint quarter_wave [DEPTH+1];
  particle_t pending_q[$];
  vertex_t   corner_q[$];
  int mismatches = 0;
  int n_live = 0, n_dead = 0, n_cfg = 0, n_vert = 0;
  bit stim_done = 1'b0;

  function automatic longint wave_entry(longint unsigned i);
    longint unsigned x, t, t2, a, s, e;
    x = (i * ONE_Q30) / DEPTH;
    t = (x * PI2_Q30) >> 30;
    t2 = (t * t) >> 30;
    a = ONE_Q30 - t2 / 72;
    a = ONE_Q30 - ((t2 * a) >> 30) / 42;
    a = ONE_Q30 - ((t2 * a) >> 30) / 20;
    a = ONE_Q30 - ((t2 * a) >> 30) / 6;
    s = (t * a) >> 30;
    e = (s + 32768) >> 16;
    if (e > 16384) e = 16384;
    return longint'(e);
  endfunction

  function automatic longint sine_lookup(logic [15:0] a);
    longint idx, m;
    idx = (longint'(a[13:0]) * DEPTH) >>> 14;
    m = a[14] ? quarter_wave[DEPTH - idx] : quarter_wave[idx];
    return a[15] ? -m : m;
  endfunction

  function automatic longint half_up_q16(longint v);
    return (v + (longint'(1) <<< 20)) >>> 21;
  endfunction

  function automatic logic signed [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic expand_quad(particle_t p);
    longint c, s, nr, nu;
    longint hr [3];
    longint hu [3];
    longint pp [3];
    longint sr, su;
    vertex_t vx;
    if (!p.live) return;
    s = sine_lookup(p.ang);
    c = sine_lookup(p.ang + 16'd16384);
    pp[0] = p.px; pp[1] = p.py; pp[2] = p.pz;
    for (int j = 0; j < 3; j++) begin
      nr = longint'(axis_r[j]) * c - longint'(axis_u[j]) * s;
      nu = longint'(axis_r[j]) * s + longint'(axis_u[j]) * c;
      hr[j] = half_up_q16(nr * longint'(p.w));
      hu[j] = half_up_q16(nu * longint'(p.h));
    end
    for (int k = 0; k < 4; k++) begin
      sr = (k == 1 || k == 2) ? 1 : -1;
      su = (k >= 2) ? 1 : -1;
      vx.x = clamp_q16(pp[0] + sr * hr[0] + su * hu[0]);
      vx.y = clamp_q16(pp[1] + sr * hr[1] + su * hu[1]);
      vx.z = clamp_q16(pp[2] + sr * hr[2] + su * hu[2]);
      vx.u = (sr > 0) ? 18'(p.tu) + 18'(p.tw) : 18'(p.tu);
      vx.v = (su > 0) ? 18'(p.tv) + 18'(p.th) : 18'(p.tv);
      vx.rgba = p.rgba;
      vx.corner = 2'(k);
      vx.last = (k == 3);
      corner_q = {corner_q, vx};
    end
  endtask

  // Driver: bursts of transfers with random gaps; register writes and drain
  // markers wait until every expected corner has arrived.
  int gap = 0, burst = 0, hold = 0;
  bit drive_valid, drive_we;
  always @(posedge clk) begin
    if (rst_n) begin
      drive_valid = in_valid && in_stall;
      drive_we = 1'b0;
      if (in_valid && !in_stall) begin
        if (live) n_live++; else n_dead++;
      end
      if (!(in_valid && in_stall)) begin
        if (hold > 0) begin
          if (corner_q.size() == 0) hold--;
        end else if (gap > 0) begin
          gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].is_cfg || pending_q[0].drain) begin
            if (corner_q.size() == 0 && !(in_valid && !in_stall && live)) begin
              if (pending_q[0].is_cfg) begin
                drive_we = 1'b1;
                cfg_idx <= pending_q[0].cidx;
                cfg_data <= pending_q[0].cval;
                if (pending_q[0].cidx <= REG_UP_Z) begin
                  if (pending_q[0].cidx < REG_UP_X) axis_r[pending_q[0].cidx] = pending_q[0].cval;
                  else axis_u[pending_q[0].cidx - REG_UP_X] = pending_q[0].cval;
                end
                n_cfg++;
                void'(pending_q.pop_front());
              end else begin
                hold = 12;
                void'(pending_q.pop_front());
              end
            end
          end else begin
            particle_t p;
            p = pending_q.pop_front();
            drive_valid = 1'b1;
            live <= p.live; pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
            width <= p.w; height <= p.h; angle <= p.ang;
            tex_u <= p.tu; tex_v <= p.tv; tex_w <= p.tw; tex_h <= p.th;
            rgba <= p.rgba;
            expand_quad(p);
            if (burst > 0) burst--;
            else begin
              burst = $urandom_range(0, 12);
              gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end else begin
          stim_done <= 1'b1;
        end
      end
      in_valid <= drive_valid;
      cfg_we <= drive_we;
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase++;
      out_stall <= (stall_phase % 64 < 20) ? 1'b0 :
                   (stall_phase % 7 == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
      if (out_valid && !out_stall) begin
        n_vert++;
        if (corner_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected corner transfer %0d", corner);
        end else begin
          vertex_t e;
          e = corner_q.pop_front();
          if (e.x !== vert_x || e.y !== vert_y || e.z !== vert_z || e.u !== coord_u ||
              e.v !== coord_v || e.rgba !== vert_rgba || e.corner !== corner ||
              e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h %h %h %h %h %h %0d %b got %h %h %h %h %h %h %0d %b",
                       e.x, e.y, e.z, e.u, e.v, e.rgba, e.corner, e.last,
                       vert_x, vert_y, vert_z, coord_u, coord_v, vert_rgba, corner, last);
          end
        end
      end
    end
  end

  function automatic particle_t rand_particle();
    particle_t p;
    p = '{default: '0};
    p.live = ($urandom_range(0, 7) != 0);
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    if ($urandom_range(0, 1)) begin
      p.px = p.px >>> 8; p.py = p.py >>> 8; p.pz = p.pz >>> 8;
    end
    p.w = 16'($urandom); p.h = 16'($urandom); p.ang = 16'($urandom);
    p.tu = 17'($urandom_range(0, 65536)); p.tv = 17'($urandom_range(0, 65536));
    p.tw = 17'($urandom_range(0, 65536)); p.th = 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 9) == 0) begin
      p.tu = 17'($urandom); p.tw = 17'($urandom); p.tv = 17'($urandom); p.th = 17'($urandom);
    end
    p.rgba = $urandom;
    return p;
  endfunction

  task automatic queue_cfg(logic [2:0] idx, logic [15:0] val);
    particle_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1; p.cidx = idx; p.cval = val;
    pending_q = {pending_q, p};
  endtask

  task automatic queue_drain();
    particle_t p;
    p = '{default: '0};
    p.drain = 1'b1;
    pending_q = {pending_q, p};
  endtask

  task automatic queue_axes(logic [15:0] v0, v1, v2, v3, v4, v5);
    queue_drain();
    queue_cfg(REG_RIGHT_X, v0); queue_cfg(REG_RIGHT_Y, v1); queue_cfg(REG_RIGHT_Z, v2);
    queue_cfg(REG_UP_X, v3); queue_cfg(REG_UP_Y, v4); queue_cfg(REG_UP_Z, v5);
  endtask

  initial begin
    particle_t p;
    logic [15:0] angs [6] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hffff, 16'd100};
    axis_r[0] = 16384; axis_r[1] = 0; axis_r[2] = 0;
    axis_u[0] = 0; axis_u[1] = 16384; axis_u[2] = 0;
    for (int i = 0; i <= DEPTH; i++) quarter_wave[i] = wave_entry(i);

    for (int i = 0; i < 6; i++) begin
      p = rand_particle();
      p.live = 1'b1; p.ang = angs[i];
      pending_q = {pending_q, p};
    end
    p = rand_particle(); p.live = 1'b0; pending_q = {pending_q, p};
    p = rand_particle(); p.live = 1'b1; p.px = 32'sh7fffffff; p.py = 32'sh80000000;
    p.pz = 32'sh7fff0000; p.w = 16'hffff; p.h = 16'hffff; pending_q = {pending_q, p};
    p.px = 32'sh80000000; p.py = 32'sh7fffffff; p.ang = 16'd8192; pending_q = {pending_q, p};
    p = rand_particle(); p.live = 1'b1; p.w = '0; p.h = '0;
    p.tu = 17'h1ffff; p.tw = 17'h1ffff; p.tv = 17'h1ffff; p.th = 17'h1ffff;
    pending_q = {pending_q, p};
    p = rand_particle(); p.live = 1'b1; p.tu = 17'd65536; p.tv = '0; p.tw = 17'd65536;
    p.th = '0;
    p.rgba = 32'hffffffff; pending_q = {pending_q, p};
    p.rgba = '0; p.px = '0; p.py = '0; p.pz = '0; pending_q = {pending_q, p};

    queue_axes(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    for (int i = 0; i < 6; i++) begin
      p = rand_particle(); p.live = 1'b1; p.w = 16'hffff; p.h = 16'hffff; p.ang = angs[i];
      pending_q = {pending_q, p};
    end
    queue_drain();
    queue_cfg(3'd6, 16'h1234);
    queue_cfg(3'd7, 16'h4321);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) queue_axes(16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0);
      else queue_axes(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < 65; i++) pending_q = {pending_q, rand_particle()};
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && corner_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d live and %0d inactive particles, %0d corners, %0d register writes.",
             n_live, n_dead, n_vert, n_cfg);
    if (mismatches == 0 && corner_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== billboard_quad_expander_core.f =====
+incdir+hdl
hdl/bqe_pkg.sv
hdl/bqe_fifo.sv
hdl/bqe_front.sv
hdl/bqe_back.sv
hdl/billboard_quad_expander_core.sv
tb/tb.sv
